### rtl/tsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants of the TSC charge deposition block
// Transaction payloads, configuration indexes, action codes, controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int DEF_MAX_GRID_WIDTH  = 256;
    localparam int DEF_MAX_GRID_HEIGHT = 256;
    localparam int DEF_ACC_WIDTH       = 48;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_DX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_DY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_VOLUME = 3'd4;

    localparam logic [8:0]  GRID_SIZE_RESET = 9'd256;
    localparam logic [31:0] INV_RESET       = 32'h0100_0000;

    localparam logic [1:0] ACT_DEPOSIT    = 2'd0;
    localparam logic [1:0] ACT_READ       = 2'd1;
    localparam logic [1:0] ACT_READ_CLEAR = 2'd2;

    localparam int DIVIDEND_W = 26;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] charge;
        logic [7:0]         cell_x;
        logic [7:0]         cell_y;
    } item_t;

    typedef struct packed {
        logic signed [47:0] cell_value;
        logic               saturated;
    } result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_MODX_GO,
        ST_MODX_WAIT,
        ST_MODY_GO,
        ST_MODY_WAIT,
        ST_INIT,
        ST_QW,
        ST_CELL_A,
        ST_CELL_B,
        ST_RD_ISSUE,
        ST_RD_CAP
    } state_t;

    typedef enum logic [2:0] {
        M1_NONE,
        M1_X,
        M1_Y,
        M1_Q,
        M1_GX,
        M1_FX,
        M1_GY,
        M1_FY
    } m1_op_t;

    typedef enum logic [2:0] {
        M2_NONE,
        M2_W0,
        M2_W1,
        M2_W2,
        M2_CELL
    } m2_op_t;

    typedef struct packed {
        logic       in_take;
        m1_op_t     mul1_op;
        m2_op_t     mul2_op;
        logic       mod_start;
        logic       mod_axis;
        logic       mod_src_cell;
        logic       cell_init;
        logic       step_x;
        logic       step_row;
        logic [1:0] wsel_x;
        logic [1:0] wsel_y;
        logic       ram_rd;
        logic       ram_wr_acc;
        logic       ram_wr_zero;
        logic       clr_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

### rtl/tsc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_ram: generic memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsc_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/tsc_mod_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_mod_unit: bit-serial modulo
// Restoring remainder, one dividend bit per cycle, with a sign fix so that
// a negative dividend yields a remainder in the range 0 to divisor-1.
// ----------------------------------------------------------------------------
module tsc_mod_unit #(
    parameter int DW = 26,
    parameter int NW = 9
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic          neg,
    input  wire logic [NW-1:0] divisor,
    output logic               done,
    output logic [NW-1:0]      rem_out
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] div_reg;
    logic          neg_reg;
    logic [NW:0]   trial;
    logic [NW-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DW-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = NW'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = NW'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done    = done_reg;
    assign rem_out = (neg_reg && (rem_reg != '0)) ? (div_reg - rem_reg) : rem_reg;

endmodule
`default_nettype wire

### rtl/tsc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_datapath: arithmetic, grid store and result register
// Configuration registers, the two multipliers, TSC weights, cell indexing,
// the saturating read-modify-write of the grid and the output register.
// ----------------------------------------------------------------------------
module tsc_datapath #(
    parameter int MAX_GRID_WIDTH  = tsc_pkg::DEF_MAX_GRID_WIDTH,
    parameter int MAX_GRID_HEIGHT = tsc_pkg::DEF_MAX_GRID_HEIGHT,
    parameter int ACC_WIDTH       = tsc_pkg::DEF_ACC_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    input  wire logic [tsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                      cfg_data,
    input  wire tsc_pkg::item_t                   item,
    input  wire tsc_pkg::cmd_t                    cmd,
    output tsc_pkg::sts_t                         sts,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output tsc_pkg::result_t                      result
);

    import tsc_pkg::*;

    localparam int XW    = $clog2(MAX_GRID_WIDTH);
    localparam int YW    = $clog2(MAX_GRID_HEIGHT);
    localparam int NXW   = $clog2(MAX_GRID_WIDTH + 1);
    localparam int NYW   = $clog2(MAX_GRID_HEIGHT + 1);
    localparam int MW    = (NXW > NYW) ? NXW : NYW;
    localparam int DEPTH = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = ((ACC_WIDTH > 48) ? ACC_WIDTH : 48) + 1;
    localparam int RW    = ACC_WIDTH + 1;

    // Configuration registers.
    logic [8:0]  gw_reg;
    logic [8:0]  gh_reg;
    logic [31:0] idx_reg;
    logic [31:0] idy_reg;
    logic [31:0] ivol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg   <= GRID_SIZE_RESET;
            gh_reg   <= GRID_SIZE_RESET;
            idx_reg  <= INV_RESET;
            idy_reg  <= INV_RESET;
            ivol_reg <= INV_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:      gw_reg   <= cfg_data[8:0];
                CFG_GRID_HEIGHT:     gh_reg   <= cfg_data[8:0];
                CFG_INV_CELL_DX:     idx_reg  <= cfg_data;
                CFG_INV_CELL_DY:     idy_reg  <= cfg_data;
                CFG_INV_CELL_VOLUME: ivol_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [NXW-1:0] nx;
    logic [NYW-1:0] ny;

    always_comb
    begin
        if (gw_reg == '0)
        begin
            nx = NXW'(1);
        end
        else if (int'(gw_reg) > MAX_GRID_WIDTH)
        begin
            nx = NXW'(MAX_GRID_WIDTH);
        end
        else
        begin
            nx = NXW'(gw_reg);
        end
        if (gh_reg == '0)
        begin
            ny = NYW'(1);
        end
        else if (int'(gh_reg) > MAX_GRID_HEIGHT)
        begin
            ny = NYW'(MAX_GRID_HEIGHT);
        end
        else
        begin
            ny = NYW'(gh_reg);
        end
    end

    // Latched transaction.
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] ch_reg;
    logic [7:0]         cx_in_reg;
    logic [7:0]         cy_in_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.in_take)
        begin
            px_reg    <= item.pos_x;
            py_reg    <= item.pos_y;
            ch_reg    <= item.charge;
            cx_in_reg <= item.cell_x;
            cy_in_reg <= item.cell_y;
        end
    end

    // First multiplier: scaling, charge density and weight squares.
    logic [DIVIDEND_W-1:0] i0x_reg;
    logic [DIVIDEND_W-1:0] i0y_reg;
    logic [15:0]           fx_reg;
    logic [15:0]           fy_reg;
    logic signed [47:0]    q_reg;
    logic [16:0]           w0x_reg;
    logic [16:0]           w2x_reg;
    logic [16:0]           w0y_reg;
    logic [16:0]           w2y_reg;
    logic signed [32:0]    m1_a;
    logic signed [32:0]    m1_b;
    logic signed [65:0]    prod1_reg;
    m1_op_t                op1_d_reg;
    logic [16:0]           gx;
    logic [16:0]           gy;
    logic [41:0]           h_cap;
    logic [65:0]           q_round;
    logic [33:0]           sq_round;

    assign gx = 17'h10000 - {1'b0, fx_reg};
    assign gy = 17'h10000 - {1'b0, fy_reg};

    always_comb
    begin
        case (cmd.mul1_op)
            M1_X:
            begin
                m1_a = {px_reg[31], px_reg};
                m1_b = {1'b0, idx_reg};
            end
            M1_Y:
            begin
                m1_a = {py_reg[31], py_reg};
                m1_b = {1'b0, idy_reg};
            end
            M1_Q:
            begin
                m1_a = {ch_reg[31], ch_reg};
                m1_b = {1'b0, ivol_reg};
            end
            M1_GX:
            begin
                m1_a = {16'b0, gx};
                m1_b = {16'b0, gx};
            end
            M1_FX:
            begin
                m1_a = {17'b0, fx_reg};
                m1_b = {17'b0, fx_reg};
            end
            M1_GY:
            begin
                m1_a = {16'b0, gy};
                m1_b = {16'b0, gy};
            end
            M1_FY:
            begin
                m1_a = {17'b0, fy_reg};
                m1_b = {17'b0, fy_reg};
            end
            default:
            begin
                m1_a = '0;
                m1_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_d_reg <= M1_NONE;
        end
        else
        begin
            op1_d_reg <= cmd.mul1_op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul1_op != M1_NONE)
        begin
            prod1_reg <= m1_a * m1_b;
        end
    end

    // Scaled position floored to Q.16, then shifted by half a cell.
    assign h_cap    = 42'(prod1_reg[65:24]) - 42'd32768;
    assign q_round  = 66'(prod1_reg) + 66'd32768;
    assign sq_round = {1'b0, prod1_reg[33:1]} + 34'd32768;

    always_ff @(posedge clk)
    begin
        case (op1_d_reg)
            M1_X:
            begin
                i0x_reg <= h_cap[41:16];
                fx_reg  <= h_cap[15:0];
            end
            M1_Y:
            begin
                i0y_reg <= h_cap[41:16];
                fy_reg  <= h_cap[15:0];
            end
            M1_Q:  q_reg   <= q_round[63:16];
            M1_GX: w0x_reg <= sq_round[32:16];
            M1_FX: w2x_reg <= sq_round[32:16];
            M1_GY: w0y_reg <= sq_round[32:16];
            M1_FY: w2y_reg <= sq_round[32:16];
            default: ;
        endcase
    end

    function automatic logic [16:0] pick_weight(input logic [16:0] w0,
                                                input logic [16:0] w2,
                                                input logic [1:0]  sel);
        logic [16:0] w;
        case (sel)
            2'd0:    w = w0;
            2'd1:    w = 17'h10000 - w0 - w2;
            2'd2:    w = w2;
            default: w = '0;
        endcase
        return w;
    endfunction

    // Base cell modulo the effective grid size.
    logic                  axis_reg;
    logic [DIVIDEND_W-1:0] mod_dividend;
    logic                  mod_neg;
    logic [MW-1:0]         mod_divisor;
    logic                  mod_done;
    logic [MW-1:0]         mod_rem;
    logic [XW-1:0]         bx_reg;
    logic [YW-1:0]         by_reg;
    logic [DIVIDEND_W-1:0] i0_sel;

    always_comb
    begin
        i0_sel = cmd.mod_axis ? i0y_reg : i0x_reg;
        if (cmd.mod_src_cell)
        begin
            mod_dividend = cmd.mod_axis ? DIVIDEND_W'(cy_in_reg) : DIVIDEND_W'(cx_in_reg);
            mod_neg      = 1'b0;
        end
        else
        begin
            mod_dividend = i0_sel[DIVIDEND_W-1] ? (~i0_sel + DIVIDEND_W'(1)) : i0_sel;
            mod_neg      = i0_sel[DIVIDEND_W-1];
        end
        mod_divisor = cmd.mod_axis ? MW'(ny) : MW'(nx);
    end

    tsc_mod_unit #(
        .DW(DIVIDEND_W),
        .NW(MW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (mod_dividend),
        .neg      (mod_neg),
        .divisor  (mod_divisor),
        .done     (mod_done),
        .rem_out  (mod_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.mod_start)
        begin
            axis_reg <= cmd.mod_axis;
        end
        if (mod_done)
        begin
            if (axis_reg)
            begin
                by_reg <= YW'(mod_rem);
            end
            else
            begin
                bx_reg <= XW'(mod_rem);
            end
        end
    end

    // Current cell, stepped with wrap-around.
    logic [XW-1:0] jx_reg;
    logic [YW-1:0] jy_reg;
    logic [XW-1:0] jx_inc;
    logic [YW-1:0] jy_inc;
    logic [AW-1:0] cell_addr;

    assign jx_inc = ((NXW'(jx_reg) + NXW'(1)) == nx) ? '0 : (jx_reg + XW'(1));
    assign jy_inc = ((NYW'(jy_reg) + NYW'(1)) == ny) ? '0 : (jy_reg + YW'(1));
    assign cell_addr = AW'(jy_reg) * AW'(MAX_GRID_WIDTH) + AW'(jx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.cell_init)
        begin
            jx_reg <= bx_reg;
            jy_reg <= by_reg;
        end
        else if (cmd.step_x)
        begin
            jx_reg <= jx_inc;
        end
        else if (cmd.step_row)
        begin
            jx_reg <= bx_reg;
            jy_reg <= jy_inc;
        end
    end

    // Second multiplier: charge times x weight, then times y weight.
    logic signed [47:0] cxw_reg [3];
    logic signed [47:0] m2_a;
    logic [16:0]        m2_w;
    logic signed [65:0] prod2_reg;
    m2_op_t             op2_d_reg;
    logic [65:0]        c_round;
    logic signed [47:0] c_val;

    always_comb
    begin
        m2_a = q_reg;
        case (cmd.mul2_op)
            M2_W0:   m2_w = pick_weight(w0x_reg, w2x_reg, 2'd0);
            M2_W1:   m2_w = pick_weight(w0x_reg, w2x_reg, 2'd1);
            M2_W2:   m2_w = pick_weight(w0x_reg, w2x_reg, 2'd2);
            M2_CELL:
            begin
                m2_a = cxw_reg[cmd.wsel_x];
                m2_w = pick_weight(w0y_reg, w2y_reg, cmd.wsel_y);
            end
            default: m2_w = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op2_d_reg <= M2_NONE;
        end
        else
        begin
            op2_d_reg <= cmd.mul2_op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul2_op != M2_NONE)
        begin
            prod2_reg <= m2_a * $signed({1'b0, m2_w});
        end
    end

    assign c_round = 66'(prod2_reg) + 66'd32768;
    assign c_val   = c_round[63:16];

    always_ff @(posedge clk)
    begin
        case (op2_d_reg)
            M2_W0:   cxw_reg[0] <= c_val;
            M2_W1:   cxw_reg[1] <= c_val;
            M2_W2:   cxw_reg[2] <= c_val;
            default: ;
        endcase
    end

    // Grid store and saturating accumulate.
    logic [RW-1:0]             rd_data;
    logic [RW-1:0]             wr_data;
    logic [AW-1:0]             wr_addr;
    logic                      wr_en;
    logic [AW-1:0]             clr_addr_reg;
    logic signed [ACC_WIDTH-1:0] acc_old;
    logic signed [SW-1:0]      acc_ext;
    logic signed [SW-1:0]      sum;
    logic signed [SW-1:0]      sum_sat;
    logic                      mark_new;
    logic signed [SW-1:0]      acc_max;
    logic signed [SW-1:0]      acc_min;
    logic signed [SW-1:0]      out_max;
    logic signed [SW-1:0]      out_min;
    logic signed [SW-1:0]      out_val;

    assign acc_max = {{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    assign acc_min = {{(SW - ACC_WIDTH + 1){1'b1}}, {(ACC_WIDTH - 1){1'b0}}};
    assign out_max = {{(SW - 47){1'b0}}, {47{1'b1}}};
    assign out_min = {{(SW - 47){1'b1}}, {47{1'b0}}};

    always_comb
    begin
        acc_old  = rd_data[ACC_WIDTH-1:0];
        acc_ext  = SW'(acc_old);
        sum      = acc_ext + SW'(c_val);
        mark_new = rd_data[ACC_WIDTH];
        if (sum > acc_max)
        begin
            sum_sat  = acc_max;
            mark_new = 1'b1;
        end
        else if (sum < acc_min)
        begin
            sum_sat  = acc_min;
            mark_new = 1'b1;
        end
        else
        begin
            sum_sat = sum;
        end
        if (acc_ext > out_max)
        begin
            out_val = out_max;
        end
        else if (acc_ext < out_min)
        begin
            out_val = out_min;
        end
        else
        begin
            out_val = acc_ext;
        end
    end

    assign wr_en   = cmd.clr_step || cmd.ram_wr_acc || cmd.ram_wr_zero;
    assign wr_addr = cmd.clr_step ? clr_addr_reg : cell_addr;
    assign wr_data = cmd.ram_wr_acc ? {mark_new, sum_sat[ACC_WIDTH-1:0]} : '0;

    tsc_ram #(
        .WIDTH(RW),
        .DEPTH(DEPTH)
    ) u_grid (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.ram_rd),
        .rd_addr (cell_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Result register.
    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;

    assign result_valid_next = cmd.out_load ? 1'b1 :
                               (result_ready ? 1'b0 : result_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.cell_value <= out_val[47:0];
            result_reg.saturated  <= rd_data[ACC_WIDTH];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign sts.mod_done = mod_done;
    assign sts.clr_last = (clr_addr_reg == AW'(DEPTH - 1));
    assign sts.out_free = !result_valid_reg || result_ready;

endmodule
`default_nettype wire

### rtl/tsc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_ctrl: controller
// Sequences the clearing pass, the setup multiplies, the modulo steps, the
// nine cell updates of a deposit and the read of one cell.
// ----------------------------------------------------------------------------
module tsc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire logic [1:0]      item_action,
    output logic                 item_ready,
    output tsc_pkg::cmd_t        cmd,
    input  wire tsc_pkg::sts_t   sts
);

    import tsc_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic [1:0] dx_reg;
    logic [1:0] dx_next;
    logic [1:0] dy_reg;
    logic [1:0] dy_next;
    logic [1:0] act_reg;
    logic [1:0] act_next;
    logic       is_deposit;

    assign is_deposit = (act_reg == ACT_DEPOSIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            act_reg   <= ACT_DEPOSIT;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            act_reg   <= act_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        act_next   = act_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    act_next  = item_action;
                    step_next = '0;
                    if (item_action == ACT_DEPOSIT)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (item_action inside {ACT_READ, ACT_READ_CLEAR})
                    begin
                        state_next = ST_MODX_GO;
                    end
                end
            end
            ST_MUL:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    state_next = ST_MODX_GO;
                end
            end
            ST_MODX_GO:   state_next = ST_MODX_WAIT;
            ST_MODX_WAIT:
            begin
                if (sts.mod_done)
                begin
                    state_next = ST_MODY_GO;
                end
            end
            ST_MODY_GO:   state_next = ST_MODY_WAIT;
            ST_MODY_WAIT:
            begin
                if (sts.mod_done)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                step_next  = '0;
                state_next = is_deposit ? ST_QW : ST_RD_ISSUE;
            end
            ST_QW:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    dx_next    = '0;
                    dy_next    = '0;
                    state_next = ST_CELL_A;
                end
            end
            ST_CELL_A:    state_next = ST_CELL_B;
            ST_CELL_B:
            begin
                if (dx_reg != 2'd2)
                begin
                    dx_next    = dx_reg + 2'd1;
                    state_next = ST_CELL_A;
                end
                else if (dy_reg != 2'd2)
                begin
                    dx_next    = '0;
                    dy_next    = dy_reg + 2'd1;
                    state_next = ST_CELL_A;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_ISSUE:  state_next = ST_RD_CAP;
            ST_RD_CAP:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul1_op  = M1_NONE;
        cmd.mul2_op  = M2_NONE;
        cmd.wsel_x   = dx_reg;
        cmd.wsel_y   = dy_reg;
        cmd.mod_src_cell = !is_deposit;
        item_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:     cmd.clr_step = 1'b1;
            ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.in_take = item_valid;
            end
            ST_MUL:
            begin
                case (step_reg)
                    3'd0:    cmd.mul1_op = M1_X;
                    3'd1:    cmd.mul1_op = M1_Y;
                    3'd2:    cmd.mul1_op = M1_Q;
                    3'd3:    cmd.mul1_op = M1_GX;
                    3'd4:    cmd.mul1_op = M1_FX;
                    3'd5:    cmd.mul1_op = M1_GY;
                    3'd6:    cmd.mul1_op = M1_FY;
                    default: cmd.mul1_op = M1_NONE;
                endcase
            end
            ST_MODX_GO:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_axis  = 1'b0;
            end
            ST_MODY_GO:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_axis  = 1'b1;
            end
            ST_INIT:      cmd.cell_init = 1'b1;
            ST_QW:
            begin
                case (step_reg)
                    3'd0:    cmd.mul2_op = M2_W0;
                    3'd1:    cmd.mul2_op = M2_W1;
                    3'd2:    cmd.mul2_op = M2_W2;
                    default: cmd.mul2_op = M2_NONE;
                endcase
            end
            ST_CELL_A:
            begin
                cmd.mul2_op = M2_CELL;
                cmd.ram_rd  = 1'b1;
            end
            ST_CELL_B:
            begin
                cmd.ram_wr_acc = 1'b1;
                if (dx_reg != 2'd2)
                begin
                    cmd.step_x = 1'b1;
                end
                else if (dy_reg != 2'd2)
                begin
                    cmd.step_row = 1'b1;
                end
            end
            ST_RD_ISSUE:  cmd.ram_rd = 1'b1;
            ST_RD_CAP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.ram_wr_zero = (act_reg == ACT_READ_CLEAR);
                end
            end
            default: ;
        endcase
    end

    a_cell_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CELL_A |=> state_reg == ST_CELL_B)
        else $error("cell read not followed by its write");

    a_mod_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mod_done |-> (state_reg == ST_MODX_WAIT || state_reg == ST_MODY_WAIT))
        else $error("modulo result arrived outside a wait state");

    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending result");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_CLEAR |=> state_reg != ST_CLEAR)
        else $error("clearing pass restarted");

endmodule
`default_nettype wire

### rtl/tsc_charge_deposit_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_charge_deposit_top: TSC charge deposition onto a periodic 2-D grid
// Deposits particle charge with quadratic weights into a 3x3 cell
// neighborhood of a saturating Q24.24 grid and reads cells back.
// ----------------------------------------------------------------------------
// Usage:
// A transaction on the item channel carries an action. A deposit scales the
// position, forms three weights per axis and adds into nine cells; it yields
// no result. A read, or a read-and-clear, returns one transaction on the
// result channel with the cell value and its sticky saturation mark. Action
// code three is accepted and dropped.
// The block works on one item at a time. A deposit passes through the setup
// multiplies, one pass per axis in the bit-serial modulo unit (26 dividend
// bits), the x weight products and, per cell, a read state and a write state
// for the read-modify-write of the grid memory. A read runs the same two
// modulo passes, then a memory read and the load of the result register.
// The result register parts the two sides: a waiting result does not block
// a following deposit; only the next read waits for the receiver.
// After reset the block clears all MAX_GRID_WIDTH*MAX_GRID_HEIGHT cells of
// the grid memory (65536 by default), one cell per cycle, with item_ready
// low. Configuration writes are always ready and must be made while idle.
// ----------------------------------------------------------------------------
module tsc_charge_deposit_top #(
    parameter int MAX_GRID_WIDTH  = tsc_pkg::DEF_MAX_GRID_WIDTH,
    parameter int MAX_GRID_HEIGHT = tsc_pkg::DEF_MAX_GRID_HEIGHT,
    parameter int ACC_WIDTH       = tsc_pkg::DEF_ACC_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire tsc_pkg::item_t                item,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output tsc_pkg::result_t                   result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    import tsc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Configuration registers take a write in any cycle.
    assign cfg_ready = 1'b1;

    tsc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_action (item.action),
        .item_ready  (item_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    tsc_datapath #(
        .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
        .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT),
        .ACC_WIDTH       (ACC_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the TSC charge deposition block
// A directed table covers reset contents, the weight extremes, saturation
// and the unused action code. Random phases under changing grid and scale
// settings follow. Every read is checked against a local grid predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import tsc_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int GRID_W        = 256;
    localparam int GRID_H        = 256;
    localparam longint ACC_MAX   = (64'sd1 <<< 47) - 1;
    localparam longint ACC_MIN   = -ACC_MAX - 1;
    // A deposit in flight finishes well within this drain.
    localparam int DRAIN_CYCLES  = 150;
    // The clearing pass after reset accepts no items; this limit outlasts it.
    localparam int WATCHDOG_LIM  = 200000;
    localparam int PHASES        = 10;
    localparam int ITEMS_PER_PH  = 130;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    item_t item;
    logic result_valid;
    logic result_ready;
    result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    tsc_charge_deposit_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the block's state, updated on every accepted transaction.
    logic [8:0]  sh_width;
    logic [8:0]  sh_height;
    logic [31:0] sh_inv_dx;
    logic [31:0] sh_inv_dy;
    logic [31:0] sh_inv_vol;
    longint      density_shadow [GRID_W*GRID_H];
    bit          sat_shadow [GRID_W*GRID_H];

    result_t expected_cells[$];

    // Values typed into the directed table, checked in addition to the shadow.
    typedef struct {
        bit      on;
        result_t r;
    } typed_t;
    typed_t typed_cells[$];

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
        item_t                it;
        bit                   typed;
        result_t              r;
    } row_t;
    row_t directed_rows[$];

    int  mismatches;
    int  deposits_seen;
    int  reads_seen;
    int  cfg_writes;
    int  quiet_cycles;
    bit  no_idle;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint eff_size(logic [8:0] reg_val, int maxv);
        longint n;
        n = longint'(reg_val);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > maxv)
        begin
            n = maxv;
        end
        return n;
    endfunction

    // Signed modulo that always lands in 0..n-1.
    function automatic longint wrap_cell(longint i, longint n);
        longint r;
        r = i % n;
        if (r < 0)
        begin
            r += n;
        end
        return r;
    endfunction

    // Quadratic weights in Q0.16 and the base cell from a Q.16 scaled position.
    task automatic tsc_weights(input longint xi, output longint w[3], output longint base);
        longint h;
        longint f;
        longint g;
        h = xi - 32768;
        base = h >>> 16;
        f = h & 64'hFFFF;
        g = 65536 - f;
        w[0] = (g * g / 2 + 32768) >>> 16;
        w[2] = (f * f / 2 + 32768) >>> 16;
        w[1] = 65536 - w[0] - w[2];
    endtask

    task automatic accumulate(int unsigned addr, longint c);
        longint a;
        a = density_shadow[addr];
        if (c > 0 && a > ACC_MAX - c)
        begin
            a = ACC_MAX;
            sat_shadow[addr] = 1'b1;
        end
        else if (c < 0 && a < ACC_MIN - c)
        begin
            a = ACC_MIN;
            sat_shadow[addr] = 1'b1;
        end
        else
        begin
            a += c;
        end
        density_shadow[addr] = a;
    endtask

    task automatic shadow_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            CFG_GRID_WIDTH:      sh_width   = data[8:0];
            CFG_GRID_HEIGHT:     sh_height  = data[8:0];
            CFG_INV_CELL_DX:     sh_inv_dx  = data;
            CFG_INV_CELL_DY:     sh_inv_dy  = data;
            CFG_INV_CELL_VOLUME: sh_inv_vol = data;
            default: ;
        endcase
    endtask

    task automatic shadow_item(item_t it);
        longint nx;
        longint ny;
        longint wx[3];
        longint wy[3];
        longint bx;
        longint by;
        longint q;
        longint c;
        longint jx;
        longint jy;
        longint v;
        int unsigned addr;
        result_t r;
        nx = eff_size(sh_width, GRID_W);
        ny = eff_size(sh_height, GRID_H);
        if (it.action == ACT_DEPOSIT)
        begin
            deposits_seen++;
            tsc_weights((longint'(it.pos_x) * longint'({32'b0, sh_inv_dx})) >>> 24, wx, bx);
            tsc_weights((longint'(it.pos_y) * longint'({32'b0, sh_inv_dy})) >>> 24, wy, by);
            q = (longint'(it.charge) * longint'({32'b0, sh_inv_vol}) + 32768) >>> 16;
            // Rows outer, columns inner, each index wrapped on its own axis.
            for (int dy = 0; dy < 3; dy++)
            begin
                jy = wrap_cell(wrap_cell(by, ny) + dy, ny);
                for (int dx = 0; dx < 3; dx++)
                begin
                    jx = wrap_cell(wrap_cell(bx, nx) + dx, nx);
                    c = (q * wx[dx] + 32768) >>> 16;
                    c = (c * wy[dy] + 32768) >>> 16;
                    accumulate(int'(jy) * GRID_W + int'(jx), c);
                end
            end
        end
        else if (it.action inside {ACT_READ, ACT_READ_CLEAR})
        begin
            reads_seen++;
            addr = int'(wrap_cell(longint'(it.cell_y), ny)) * GRID_W
                 + int'(wrap_cell(longint'(it.cell_x), nx));
            v = density_shadow[addr];
            r.cell_value = v[47:0];
            r.saturated  = sat_shadow[addr];
            expected_cells.insert(expected_cells.size(), r);
            if (it.action == ACT_READ_CLEAR)
            begin
                density_shadow[addr] = 0;
                sat_shadow[addr] = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: transactions are sampled at the rising edge, before the block
    // and the drivers update. The shadow follows the order of acceptance.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t exp_r;
        typed_t  tr;
        bit      busy;
        busy = 1'b0;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            shadow_config(cfg_index, cfg_data);
            cfg_writes++;
            busy = 1'b1;
        end
        if (rst_n && item_valid && item_ready)
        begin
            shadow_item(item);
            busy = 1'b1;
        end
        if (rst_n && result_valid && result_ready)
        begin
            busy = 1'b1;
            if (expected_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: unexpected result value=%h sat=%b",
                             result.cell_value, result.saturated);
                end
            end
            else
            begin
                exp_r = expected_cells.pop_front();
                if (result.cell_value !== exp_r.cell_value ||
                    result.saturated !== exp_r.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: cell mismatch exp value=%h sat=%b got value=%h sat=%b",
                                 exp_r.cell_value, exp_r.saturated,
                                 result.cell_value, result.saturated);
                    end
                end
            end
            if (typed_cells.size() > 0)
            begin
                tr = typed_cells.pop_front();
                if (tr.on && (result.cell_value !== tr.r.cell_value ||
                              result.saturated !== tr.r.saturated))
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: directed row exp value=%h sat=%b got value=%h sat=%b",
                                 tr.r.cell_value, tr.r.saturated,
                                 result.cell_value, result.saturated);
                    end
                end
            end
        end
        // Watchdog: the run ends if nothing moves on any channel for too long.
        if (busy)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIM)
            begin
                $display("Timeout after %0d cycles with no transaction", quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: one random stall per result, none in the no_idle phases.
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
            begin
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Valid stays high across back-to-back transactions; it drops only
    // when a gap is drawn or the bench settles.
    task automatic send_item(item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Wait until every read has returned, then let a pending deposit finish.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_cells.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The write channel goes idle after each write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic item_t make_item(logic [1:0] act, logic [31:0] px, logic [31:0] py,
                                        logic [31:0] ch, logic [7:0] cx, logic [7:0] cy);
        item_t it;
        it.action = act;
        it.pos_x  = px;
        it.pos_y  = py;
        it.charge = ch;
        it.cell_x = cx;
        it.cell_y = cy;
        return it;
    endfunction

    function automatic void add_row(item_t it);
        row_t row;
        row = '{default: '0};
        row.it = it;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_read(logic [1:0] act, logic [7:0] cx, logic [7:0] cy,
                                     logic [47:0] val, bit sat);
        row_t row;
        row = '{default: '0};
        row.it = make_item(act, '0, '0, '0, cx, cy);
        row.typed = 1'b1;
        row.r.cell_value = val;
        row.r.saturated = sat;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic logic [31:0] pick_inv();
        case ($urandom_range(0, 4))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2: return INV_RESET;
            3: return $urandom_range(32'h0008_0000, 32'h0400_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [8:0] pick_size();
        case ($urandom_range(0, 4))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'($urandom_range(2, 8));
            3: return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(1, 256));
        endcase
    endfunction

    // Positions mostly land on the first few cells so that reads hit them.
    function automatic logic [31:0] pick_pos();
        if ($urandom_range(0, 9) < 7)
        begin
            return $urandom_range(0, 32'h000A_0000) - 32'h0002_0000;
        end
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_cell();
        if ($urandom_range(0, 9) < 7)
        begin
            return 8'($urandom_range(0, 9));
        end
        return 8'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        item_t it;
        typed_t tr;
        int unsigned pick;
        logic [1:0] act;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        deposits_seen = 0;
        reads_seen   = 0;
        cfg_writes   = 0;
        quiet_cycles = 0;
        no_idle      = 1'b0;
        sh_width     = GRID_SIZE_RESET;
        sh_height    = GRID_SIZE_RESET;
        sh_inv_dx    = INV_RESET;
        sh_inv_dy    = INV_RESET;
        sh_inv_vol   = INV_RESET;
        foreach (density_shadow[i])
        begin
            density_shadow[i] = 0;
            sat_shadow[i] = 1'b0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. Grid contents after reset are zero everywhere.
        add_read(ACT_READ, 8'd0, 8'd0, 48'd0, 1'b0);
        add_read(ACT_READ, 8'd255, 8'd255, 48'd0, 1'b0);
        add_row(make_item(ACT_UNUSED, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 8'd0, 8'd0));
        add_read(ACT_READ, 8'd0, 8'd0, 48'd0, 1'b0);
        // A particle at half a cell has zero fraction: weights 0.5, 0.5, 0.
        // Unit charge gives a quarter in cell (0,0).
        add_row(make_item(ACT_DEPOSIT, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 8'd0, 8'd0));
        add_read(ACT_READ_CLEAR, 8'd0, 8'd0, 48'h00_0000_40_0000, 1'b0);
        add_read(ACT_READ, 8'd0, 8'd0, 48'd0, 1'b0);
        add_row(make_item(ACT_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 8'd0, 8'd0));
        add_row(make_item(ACT_DEPOSIT, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd0));
        add_row(make_item(ACT_READ, '0, '0, '0, 8'd255, 8'd127));
        add_row(make_item(ACT_READ, '0, '0, '0, 8'd1, 8'd0));
        // Largest charge scale: repeated deposits drive cell (0,0) into both rails.
        add_cfg(CFG_INV_CELL_VOLUME, 32'hFFFF_FFFF);
        repeat (6)
        begin
            add_row(make_item(ACT_DEPOSIT, 32'h0000_8000, 32'h0000_8000, 32'h7FFF_FFFF,
                              8'd0, 8'd0));
        end
        add_read(ACT_READ_CLEAR, 8'd0, 8'd0, 48'h7FFF_FFFF_FFFF, 1'b1);
        repeat (6)
        begin
            add_row(make_item(ACT_DEPOSIT, 32'h0000_8000, 32'h0000_8000, 32'h8000_0000,
                              8'd0, 8'd0));
        end
        add_read(ACT_READ_CLEAR, 8'd0, 8'd0, 48'h8000_0000_0000, 1'b1);
        add_read(ACT_READ, 8'd0, 8'd0, 48'd0, 1'b0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                settle();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                if (directed_rows[i].it.action inside {ACT_READ, ACT_READ_CLEAR})
                begin
                    tr.on = directed_rows[i].typed;
                    tr.r  = directed_rows[i].r;
                    typed_cells.insert(typed_cells.size(), tr);
                end
                send_item(directed_rows[i].it);
            end
        end
        settle();

        // Random phases. Every register is rewritten at the start of each
        // phase; the first two phases take the low and high extremes.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            no_idle = (ph % 3 == 2);
            if (ph == 0)
            begin
                write_reg(CFG_GRID_WIDTH, 32'd1);
                write_reg(CFG_GRID_HEIGHT, 32'd0);
                write_reg(CFG_INV_CELL_DX, 32'd1);
                write_reg(CFG_INV_CELL_DY, 32'd1);
                write_reg(CFG_INV_CELL_VOLUME, 32'd1);
            end
            else if (ph == 1)
            begin
                write_reg(CFG_GRID_WIDTH, 32'd511);
                write_reg(CFG_GRID_HEIGHT, 32'd256);
                write_reg(CFG_INV_CELL_DX, 32'hFFFF_FFFF);
                write_reg(CFG_INV_CELL_DY, 32'hFFFF_FFFF);
                write_reg(CFG_INV_CELL_VOLUME, 32'hFFFF_FFFF);
            end
            else
            begin
                write_reg(CFG_GRID_WIDTH, {23'b0, pick_size()});
                write_reg(CFG_GRID_HEIGHT, {23'b0, pick_size()});
                write_reg(CFG_INV_CELL_DX, pick_inv());
                write_reg(CFG_INV_CELL_DY, pick_inv());
                write_reg(CFG_INV_CELL_VOLUME, pick_inv());
            end

            for (int n = 0; n < ITEMS_PER_PH; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 58)
                begin
                    act = ACT_DEPOSIT;
                end
                else if (pick < 78)
                begin
                    act = ACT_READ;
                end
                else if (pick < 96)
                begin
                    act = ACT_READ_CLEAR;
                end
                else
                begin
                    act = ACT_UNUSED;
                end
                it = make_item(act, pick_pos(), pick_pos(),
                               ($urandom_range(0, 1) != 0) ? $urandom
                                   : ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000),
                               pick_cell(), pick_cell());
                send_item(it);
            end
            settle();
        end

        if (expected_cells.size() != 0)
        begin
            mismatches++;
            $display("ERROR: %0d expected results never arrived", expected_cells.size());
        end

        $display("Run covered %0d deposits and %0d cell reads over %0d register writes.",
                 deposits_seen, reads_seen, cfg_writes);
        $display("Grid sizes and scale factors were swept from their minima to their maxima.");
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Mismatches: %0d", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
